// ===== sv/qacc_pkg.sv =====
// ---------------------------------------------------------------------------
// Quad angle check package
// Shared constants, register codes and the arctangent table of the angle
// pipeline.
// ---------------------------------------------------------------------------
package qacc_pkg;

  // Fraction bits of the angle accumulator, in degrees.
  localparam int ANG_FRAC = 16;
  // Accumulator width: holds +/-270 degrees with 16 fraction bits.
  localparam int ZW = 26;
  // Width of one arctangent table entry.
  localparam int ATAN_W = 22;
  // Number of entries in the arctangent table.
  localparam int ATAN_LEN = 24;
  // Half an output degree, used for rounding.
  localparam int ROUND_HALF = 1 << (ANG_FRAC - 1);

  localparam logic [7:0] DEG_0   = 8'd0;
  localparam logic [7:0] DEG_90  = 8'd90;
  localparam logic [7:0] DEG_180 = 8'd180;

  // Accumulator start value after the quarter turn.
  localparam logic signed [ZW-1:0] Z_90 = ZW'(90 << ANG_FRAC);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MIN_ANGLE    = 2'd0,
    REG_MAX_ANGLE    = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_reg_t;

  // atan(2^-i) in degrees, 16 fraction bits, rounded.
  function automatic logic [ATAN_W-1:0] atan_entry(input int unsigned idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      0:       val = 22'd2949120;
      1:       val = 22'd1740967;
      2:       val = 22'd919879;
      3:       val = 22'd466945;
      4:       val = 22'd234379;
      5:       val = 22'd117304;
      6:       val = 22'd58666;
      7:       val = 22'd29335;
      8:       val = 22'd14668;
      9:       val = 22'd7334;
      10:      val = 22'd3667;
      11:      val = 22'd1833;
      12:      val = 22'd917;
      13:      val = 22'd458;
      14:      val = 22'd229;
      15:      val = 22'd115;
      16:      val = 22'd57;
      17:      val = 22'd29;
      18:      val = 22'd14;
      19:      val = 22'd7;
      20:      val = 22'd4;
      21:      val = 22'd2;
      22:      val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/qacc_if.sv =====
// ---------------------------------------------------------------------------
// Quad angle check stream interfaces
// Valid/ready channels for the corner words and the result words.
// ---------------------------------------------------------------------------
interface qacc_corner_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] corner0_x;
  logic signed [CW-1:0] corner0_y;
  logic signed [CW-1:0] corner1_x;
  logic signed [CW-1:0] corner1_y;
  logic signed [CW-1:0] corner2_x;
  logic signed [CW-1:0] corner2_y;
  logic signed [CW-1:0] corner3_x;
  logic signed [CW-1:0] corner3_y;

  modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y,
                  corner2_x, corner2_y, corner3_x, corner3_y, input ready);
  modport sink   (input valid, corner0_x, corner0_y, corner1_x, corner1_y,
                  corner2_x, corner2_y, corner3_x, corner3_y, output ready);
endinterface

interface qacc_result_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic [7:0]           angle0;
  logic [7:0]           angle1;
  logic [7:0]           angle2;
  logic [7:0]           angle3;
  logic                 shape_ok;
  logic                 center_found;
  logic signed [CW-1:0] offset_x;
  logic signed [CW-1:0] offset_y;

  modport source (output valid, angle0, angle1, angle2, angle3, shape_ok,
                  center_found, offset_x, offset_y, input ready);
  modport sink   (input valid, angle0, angle1, angle2, angle3, shape_ok,
                  center_found, offset_x, offset_y, output ready);
endinterface

// ===== sv/quad_angle_check_and_center.sv =====
// ---------------------------------------------------------------------------
// Quadrilateral inner angle check and diagonal center offset
// Measures the four inner angles of a quadrilateral, checks them against
// the angle bounds and reports where the diagonals cross, relative to the
// frame center.
// ---------------------------------------------------------------------------
// Usage:
// The corners channel takes one word of four corners (signed, 1/16 pixel)
// per cycle while ready is high. The result channel gives one word per
// corner word, in order: four angles in whole degrees, the shape flag, the
// center flag and the saturated crossing offset. Both channels use
// valid/ready. The depth is set by the longer of the chain of restoring
// divider cells, one quotient bit per active cell, and the chain of CORDIC
// cells, one rotation per active cell, which run side by side.
// Every stage keeps its own valid bit and moves up when the stage ahead is
// free, so empty stages fill while a result waits; ready on the corners
// channel drops only when every stage holds a word and the receiver stalls.
// Reset clears the pipeline and loads the default bounds (60 and 120
// degrees) and frame size (640 by 480). Registers are to be written only
// while the pipeline is empty; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module quad_angle_check_and_center
  import qacc_pkg::*;
#(
  parameter int COORD_WIDTH      = 16,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [12:0]          cfg_data,
  qacc_corner_if.sink          corners,
  qacc_result_if.source        result
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * CW + 2;
  localparam int MW   = PW;
  localparam int AMW  = CW + 1;
  localparam int LW   = CW + 1;
  localparam int HW   = MW - LW;
  localparam int AW   = AMW + MW;
  localparam int CMAX = (CW > 16) ? CW : 16;
  localparam int QW   = CMAX + 2;
  localparam int QB   = QW + 1;
  localparam int RW   = (AW > MW + QW) ? AW : MW + QW;
  localparam int SW   = CMAX + 4;
  localparam int XW   = 2 * CW + 5;
  localparam int TW   = 9;
  localparam int DTW  = SW + 2;
  localparam int NC   = (ANGLE_ITERATIONS > QB + 2) ? ANGLE_ITERATIONS : QB + 2;
  localparam int ND   = NC - 2;
  localparam int NS   = NC + 5;
  localparam longint OMAXL = (longint'(1) << (CW - 1)) - 1;
  localparam logic signed [SW-1:0] OMAX = SW'(OMAXL);
  localparam logic signed [SW-1:0] OMIN = SW'(-OMAXL - 1);

  // Configuration registers.
  logic [7:0]  min_angle;
  logic [7:0]  max_angle;
  logic [12:0] frame_width;
  logic [12:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle    <= 8'd60;
      max_angle    <= 8'd120;
      frame_width  <= 13'd640;
      frame_height <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_ANGLE:    min_angle    <= cfg_data[7:0];
        REG_MAX_ANGLE:    max_angle    <= cfg_data[7:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and the load enables that let words close up.
  logic [NS-1:0] v;
  logic [NS:0]   en;

  assign en[NS] = result.ready;
  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end
  assign corners.ready = en[0];
  assign result.valid  = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= corners.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage A: edge vectors at each corner, diagonals, center base.
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];
  logic [16:0]          c16x;
  logic [16:0]          c16y;

  always_comb begin
    px[0] = corners.corner0_x;
    py[0] = corners.corner0_y;
    px[1] = corners.corner1_x;
    py[1] = corners.corner1_y;
    px[2] = corners.corner2_x;
    py[2] = corners.corner2_y;
    px[3] = corners.corner3_x;
    py[3] = corners.corner3_y;
    c16x  = {1'b0, frame_width[12:1], 4'b0000};
    c16y  = {1'b0, frame_height[12:1], 4'b0000};
  end

  logic signed [DW-1:0] a_ux [4];
  logic signed [DW-1:0] a_uy [4];
  logic signed [DW-1:0] a_vx [4];
  logic signed [DW-1:0] a_vy [4];
  logic signed [DW-1:0] a_d1x, a_d1y, a_d2x, a_d2y, a_wx, a_wy;
  logic signed [SW-1:0] a_bx, a_by;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 4; k++) begin
        a_ux[k] <= DW'(px[k]) - DW'(px[(k+3)%4]);
        a_uy[k] <= DW'(py[k]) - DW'(py[(k+3)%4]);
        a_vx[k] <= DW'(px[k]) - DW'(px[(k+1)%4]);
        a_vy[k] <= DW'(py[k]) - DW'(py[(k+1)%4]);
      end
      a_d1x <= DW'(px[2]) - DW'(px[0]);
      a_d1y <= DW'(py[2]) - DW'(py[0]);
      a_d2x <= DW'(px[3]) - DW'(px[1]);
      a_d2y <= DW'(py[3]) - DW'(py[1]);
      a_wx  <= DW'(px[1]) - DW'(px[0]);
      a_wy  <= DW'(py[1]) - DW'(py[0]);
      a_bx  <= SW'(px[0]) - SW'(c16x);
      a_by  <= SW'(py[0]) - SW'(c16y);
    end
  end

  // Stage B: products for cross, dot, denominator and numerator.
  logic signed [PW-1:0] b_m [4][4];
  logic signed [PW-1:0] b_dn0, b_dn1, b_nm0, b_nm1;
  logic signed [DW-1:0] b_d1x, b_d1y;
  logic signed [SW-1:0] b_bx, b_by;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 4; k++) begin
        b_m[k][0] <= a_ux[k] * a_vy[k];
        b_m[k][1] <= a_uy[k] * a_vx[k];
        b_m[k][2] <= a_ux[k] * a_vx[k];
        b_m[k][3] <= a_uy[k] * a_vy[k];
      end
      b_dn0 <= a_d1x * a_d2y;
      b_dn1 <= a_d1y * a_d2x;
      b_nm0 <= a_wx * a_d2y;
      b_nm1 <= a_wy * a_d2x;
      b_d1x <= a_d1x;
      b_d1y <= a_d1y;
      b_bx  <= a_bx;
      b_by  <= a_by;
    end
  end

  // Stage C: cross and dot per corner, diagonal determinants.
  logic signed [PW-1:0] c_cross [4];
  logic signed [PW-1:0] c_dot [4];
  logic signed [PW-1:0] c_den, c_num;
  logic signed [DW-1:0] c_d1x, c_d1y;
  logic signed [SW-1:0] c_bx, c_by;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 4; k++) begin
        c_cross[k] <= b_m[k][0] - b_m[k][1];
        c_dot[k]   <= b_m[k][2] + b_m[k][3];
      end
      c_den <= b_dn0 - b_dn1;
      c_num <= b_nm0 - b_nm1;
      c_d1x <= b_d1x;
      c_d1y <= b_d1y;
      c_bx  <= b_bx;
      c_by  <= b_by;
    end
  end

  // Stage D, angle side: fold into the right half plane, catch axis cases.
  logic signed [PW-1:0] p_mag [4];
  logic signed [XW-1:0] p_x [4];
  logic signed [XW-1:0] p_y [4];
  logic signed [ZW-1:0] p_z [4];
  logic [TW-1:0]        p_tag [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      p_mag[l] = c_cross[l][PW-1] ? -c_cross[l] : c_cross[l];
      if (c_dot[l][PW-1]) begin
        p_x[l] = XW'(p_mag[l]);
        p_y[l] = -XW'(c_dot[l]);
        p_z[l] = Z_90;
      end else begin
        p_x[l] = XW'(c_dot[l]);
        p_y[l] = XW'(p_mag[l]);
        p_z[l] = '0;
      end
      if (c_cross[l] == '0) begin
        p_tag[l] = {1'b1, c_dot[l][PW-1] ? DEG_180 : DEG_0};
      end else if (c_dot[l] == '0) begin
        p_tag[l] = {1'b1, DEG_90};
      end else begin
        p_tag[l] = {1'b0, DEG_0};
      end
    end
  end

  logic signed [XW-1:0] r_x [4];
  logic signed [XW-1:0] r_y [4];
  logic signed [ZW-1:0] r_z [4];
  logic [TW-1:0]        r_tag [4];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r_x   <= p_x;
      r_y   <= p_y;
      r_z   <= p_z;
      r_tag <= p_tag;
    end
  end

  // CORDIC chain, four lanes.
  logic signed [XW-1:0] cx [NC][4];
  logic signed [XW-1:0] cy [NC][4];
  logic signed [ZW-1:0] cz [NC][4];
  logic [TW-1:0]        ct [NC][4];

  for (genvar k = 0; k < NC; k++) begin : g_cordic
    for (genvar l = 0; l < 4; l++) begin : g_lane
      if (k == 0) begin : g_first
        qacc_cordic_cell #(
          .XW(XW), .SHIFT(0), .ACTIVE(ANGLE_ITERATIONS > 0), .TW(TW)
        ) u_cell (
          .clk(clk), .load(en[4]),
          .x_in(r_x[l]), .y_in(r_y[l]), .z_in(r_z[l]), .tag_in(r_tag[l]),
          .x_out(cx[k][l]), .y_out(cy[k][l]), .z_out(cz[k][l]),
          .tag_out(ct[k][l])
        );
      end else begin : g_next
        qacc_cordic_cell #(
          .XW(XW), .SHIFT((k < ANGLE_ITERATIONS) ? k : 0),
          .ACTIVE(k < ANGLE_ITERATIONS), .TW(TW)
        ) u_cell (
          .clk(clk), .load(en[4+k]),
          .x_in(cx[k-1][l]), .y_in(cy[k-1][l]), .z_in(cz[k-1][l]),
          .tag_in(ct[k-1][l]),
          .x_out(cx[k][l]), .y_out(cy[k][l]), .z_out(cz[k][l]),
          .tag_out(ct[k][l])
        );
      end
    end
  end

  // Stage D, center side: magnitudes and signs of the crossing ratio.
  logic [AMW-1:0] d_ax, d_ay;
  logic [MW-1:0]  d_num, d_den;
  logic           d_sx, d_sy, d_found;
  logic signed [SW-1:0] d_bx, d_by;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d_ax    <= c_d1x[DW-1] ? AMW'(-c_d1x) : AMW'(c_d1x);
      d_ay    <= c_d1y[DW-1] ? AMW'(-c_d1y) : AMW'(c_d1y);
      d_num   <= c_num[PW-1] ? MW'(-c_num) : MW'(c_num);
      d_den   <= c_den[PW-1] ? MW'(-c_den) : MW'(c_den);
      d_sx    <= c_d1x[DW-1] ^ c_num[PW-1] ^ c_den[PW-1];
      d_sy    <= c_d1y[DW-1] ^ c_num[PW-1] ^ c_den[PW-1];
      d_found <= c_den != '0;
      d_bx    <= c_bx;
      d_by    <= c_by;
    end
  end

  // Partial products of the numerator, split in two halves.
  logic [AMW+LW-1:0] e_xlo, e_ylo;
  logic [AMW+HW-1:0] e_xhi, e_yhi;
  logic [MW-1:0]     e_den;
  logic              e_sx, e_sy, e_found;
  logic signed [SW-1:0] e_bx, e_by;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      e_xlo   <= d_ax * d_num[LW-1:0];
      e_xhi   <= d_ax * d_num[MW-1:LW];
      e_ylo   <= d_ay * d_num[LW-1:0];
      e_yhi   <= d_ay * d_num[MW-1:LW];
      e_den   <= d_den;
      e_sx    <= d_sx;
      e_sy    <= d_sy;
      e_found <= d_found;
      e_bx    <= d_bx;
      e_by    <= d_by;
    end
  end

  // Dividends for the two coordinates.
  logic [AW-1:0]  f_ax, f_ay;
  logic [MW-1:0]  f_den;
  logic [DTW-1:0] f_tx, f_ty;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      f_ax  <= (AW'(e_xhi) << LW) + AW'(e_xlo);
      f_ay  <= (AW'(e_yhi) << LW) + AW'(e_ylo);
      f_den <= e_den;
      f_tx  <= {e_found, e_sx, e_bx};
      f_ty  <= {e_found, e_sy, e_by};
    end
  end

  // Divider chains; the first active cell's bit flags an oversized quotient.
  logic [RW-1:0]  dr [ND][2];
  logic [MW-1:0]  dd [ND][2];
  logic [QB-1:0]  dq [ND][2];
  logic [DTW-1:0] dt [ND][2];
  logic [RW-1:0]  f_rem [2];
  logic [DTW-1:0] f_tag [2];

  assign f_rem[0] = RW'(f_ax);
  assign f_rem[1] = RW'(f_ay);
  assign f_tag[0] = f_tx;
  assign f_tag[1] = f_ty;

  for (genvar j = 0; j < ND; j++) begin : g_div
    for (genvar c = 0; c < 2; c++) begin : g_coord
      if (j == 0) begin : g_first
        qacc_div_cell #(
          .RW(RW), .BW(MW), .QB(QB), .SHIFT(QW), .ACTIVE(1'b1), .TW(DTW)
        ) u_cell (
          .clk(clk), .load(en[6]),
          .rem_in(f_rem[c]), .den_in(f_den), .quot_in('0), .tag_in(f_tag[c]),
          .rem_out(dr[j][c]), .den_out(dd[j][c]), .quot_out(dq[j][c]),
          .tag_out(dt[j][c])
        );
      end else begin : g_next
        qacc_div_cell #(
          .RW(RW), .BW(MW), .QB(QB), .SHIFT((j < QB) ? QW - j : 0),
          .ACTIVE(j < QB), .TW(DTW)
        ) u_cell (
          .clk(clk), .load(en[6+j]),
          .rem_in(dr[j-1][c]), .den_in(dd[j-1][c]), .quot_in(dq[j-1][c]),
          .tag_in(dt[j-1][c]),
          .rem_out(dr[j][c]), .den_out(dd[j][c]), .quot_out(dq[j][c]),
          .tag_out(dt[j][c])
        );
      end
    end
  end

  // Floor quotient with sign, added to the center base, then saturated.
  function automatic logic signed [CW-1:0] offset_of(
    input logic [QB-1:0]  quot,
    input logic [RW-1:0]  rem,
    input logic [DTW-1:0] tag
  );
    logic [QB-1:0]        qmag;
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] base;
    logic signed [CW-1:0] res;
    qmag = quot[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, quot[QW-1:0]};
    base = tag[SW-1:0];
    if (tag[SW]) begin
      qs = -(SW'(qmag) + SW'(rem != '0));
    end else begin
      qs = SW'(qmag);
    end
    sum = base + qs;
    if (sum > OMAX) begin
      res = CW'(OMAX);
    end else if (sum < OMIN) begin
      res = CW'(OMIN);
    end else begin
      res = CW'(sum);
    end
    return res;
  endfunction

  // Final stage: round the angles, check bounds, form the offsets.
  logic signed [ZW:0] g_r [4];
  logic [7:0]         g_ang [4];
  logic               g_ok;
  logic               g_found;

  always_comb begin
    g_ok = 1'b1;
    for (int l = 0; l < 4; l++) begin
      g_r[l] = {cz[NC-1][l][ZW-1], cz[NC-1][l]} + (ZW+1)'(ROUND_HALF);
      if (ct[NC-1][l][TW-1]) begin
        g_ang[l] = ct[NC-1][l][7:0];
      end else if (g_r[l][ZW]) begin
        g_ang[l] = DEG_0;
      end else if (g_r[l][ZW:ANG_FRAC] > (ZW+1-ANG_FRAC)'(DEG_180)) begin
        g_ang[l] = DEG_180;
      end else begin
        g_ang[l] = g_r[l][ANG_FRAC+7:ANG_FRAC];
      end
      if (!(g_ang[l] > min_angle && g_ang[l] < max_angle)) begin
        g_ok = 1'b0;
      end
    end
    g_found = dt[ND-1][0][SW+1] && dt[ND-1][1][SW+1];
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      result.angle0       <= g_ang[0];
      result.angle1       <= g_ang[1];
      result.angle2       <= g_ang[2];
      result.angle3       <= g_ang[3];
      result.shape_ok     <= g_ok;
      result.center_found <= g_found;
      result.offset_x     <= g_found ?
          offset_of(dq[ND-1][0], dr[ND-1][0], dt[ND-1][0]) : '0;
      result.offset_y     <= g_found ?
          offset_of(dq[ND-1][1], dr[ND-1][1], dt[ND-1][1]) : '0;
    end
  end

`ifndef ASSERT_OFF
  // Parallel diagonals give a zero offset.
  a_no_center_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.center_found |->
      (result.offset_x == '0 && result.offset_y == '0))
    else $error("offset not zero without a center");

  // Angles never exceed a half turn.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.angle0 <= DEG_180 && result.angle1 <= DEG_180 &&
                      result.angle2 <= DEG_180 && result.angle3 <= DEG_180))
    else $error("angle out of range");

  // A passing shape has every angle inside the bounds.
  a_shape_bounds: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.shape_ok |->
      (result.angle0 > min_angle && result.angle0 < max_angle &&
       result.angle1 > min_angle && result.angle1 < max_angle &&
       result.angle2 > min_angle && result.angle2 < max_angle &&
       result.angle3 > min_angle && result.angle3 < max_angle))
    else $error("shape flag set with an angle out of bounds");

  // The input side backs up only behind a stalled result.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !corners.ready |-> (result.valid && !result.ready))
    else $error("corners refused while the output moves");
`endif

endmodule

// ===== sv/qacc_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// Quad angle check CORDIC cell
// One vectoring rotation of the angle pipeline, registered. An inactive
// cell only carries its word to the next one.
// ---------------------------------------------------------------------------
module qacc_cordic_cell
  import qacc_pkg::*;
#(
  parameter int XW     = 37,
  parameter int SHIFT  = 0,
  parameter bit ACTIVE = 1'b1,
  parameter int TW     = 9
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic [TW-1:0]        tag_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output logic [TW-1:0]        tag_out
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] tz;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  // Rotate toward the x axis by the direction of the sign of y.
  always_comb begin
    xs = x_in >>> SHIFT;
    ys = y_in >>> SHIFT;
    tz = ZW'(atan_entry(SHIFT));
    if (!ACTIVE) begin
      x_next = x_in;
      y_next = y_in;
      z_next = z_in;
    end else if (!y_in[XW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + tz;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - tz;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_out   <= x_next;
      y_out   <= y_next;
      z_out   <= z_next;
      tag_out <= tag_in;
    end
  end

endmodule

// ===== sv/qacc_div_cell.sv =====
// ---------------------------------------------------------------------------
// Quad angle check divider cell
// One restoring division step: decides one quotient bit and passes the
// partial remainder on. An inactive cell only carries its word.
// ---------------------------------------------------------------------------
module qacc_div_cell #(
  parameter int RW     = 69,
  parameter int BW     = 34,
  parameter int QB     = 19,
  parameter int SHIFT  = 0,
  parameter bit ACTIVE = 1'b1,
  parameter int TW     = 22
) (
  input  logic          clk,
  input  logic          load,
  input  logic [RW-1:0] rem_in,
  input  logic [BW-1:0] den_in,
  input  logic [QB-1:0] quot_in,
  input  logic [TW-1:0] tag_in,
  output logic [RW-1:0] rem_out,
  output logic [BW-1:0] den_out,
  output logic [QB-1:0] quot_out,
  output logic [TW-1:0] tag_out
);

  logic [RW-1:0] dsh;
  logic [RW:0]   diff;
  logic          take;
  logic [RW-1:0] rem_next;
  logic [QB-1:0] quot_next;

  // Subtract the shifted divisor when it fits.
  always_comb begin
    dsh       = RW'(den_in) << SHIFT;
    diff      = {1'b0, rem_in} - {1'b0, dsh};
    take      = ACTIVE && !diff[RW];
    rem_next  = take ? diff[RW-1:0] : rem_in;
    quot_next = quot_in;
    if (take) begin
      quot_next[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_out  <= rem_next;
      den_out  <= den_in;
      quot_out <= quot_next;
      tag_out  <= tag_in;
    end
  end

endmodule
